// ----- src/wis_pkg.sv -----
// Package for the weighted index sampler: table sizes, word widths,
// opcode and status codes, and the sequencer state type. No dependencies.
package wis_pkg;

   // Table geometry
   localparam int MAX_KEYS = 1024;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = IDX_W + 1;

   // Word widths
   localparam int WEIGHT_W = 32;
   localparam int FRAC_W   = 32;
   localparam int TOT_W    = WEIGHT_W + IDX_W;
   localparam int PROD_W   = 2 * FRAC_W;
   localparam int PICK_W   = 10;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;

   // Opcodes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAW   = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_ADD,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DONE
   } state_type;

endpackage

// ----- src/weighted_index_sampler.sv -----
// Weighted index sampler top level: cumulative weight table, shared 32x32
// multiplier for the draw threshold, and binary search sequencer.
// Depends on wis_pkg.
//
// Usage:
//   Request words (req_valid/req_ready) carry an opcode: clear, append a
//   weight, or draw with a 32-bit uniform fraction. Every request yields
//   exactly one response word (rsp_valid/rsp_ready) with an index and a
//   status. Clear, append and unused opcodes respond in the cycle after
//   acceptance. A draw on a non-empty table computes the threshold with two
//   passes through the one multiplier and then an add, then runs a binary
//   search in which each probe is a table read and then a compare, and ends
//   with a final range check and a closing state that sends the response.
//   One request is in flight at a time; req_ready is low during a draw.
//   The response sits in an output register; a new request is accepted while
//   the pending response is taken in the same cycle. If the receiver stalls,
//   the response holds and no further request is accepted.
//   Reset empties the table (entry count and running total to zero); the
//   table storage itself is not cleared, only entries below the count are read.
module weighted_index_sampler
   import wis_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [FRAC_W-1:0]   req_uniform_fraction,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PICK_W-1:0]   rsp_picked_index,
   output logic [STAT_W-1:0]   rsp_status
);

   // Cumulative weight table
   logic [TOT_W-1:0] cum_mem [MAX_KEYS];

   // Control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [FRAC_W-1:0] u_ff, u_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [FRAC_W-1:0] acc_ff, acc_in;
   logic [TOT_W-1:0]  thr_ff, thr_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic [TOT_W-1:0]  rd_data_ff;
   logic [PICK_W-1:0] pick_ff, pick_in;
   logic [STAT_W-1:0] status_ff, status_in;

   // Combinational helpers
   logic              out_free;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [TOT_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;
   logic [CNT_W-1:0]  mid_calc;
   logic [CNT_W-1:0]  last_idx;
   logic [FRAC_W-1:0] mul_b;
   logic [PROD_W-1:0] mul_out;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_index = pick_ff;
   assign rsp_status       = status_ff;

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last_idx = (cnt_ff == '0) ? '0 : cnt_ff - CNT_W'(1);

   // Shared multiplier: low 32 bits of the total, then its high part
   assign mul_b   = (state_ff == S_MUL_LO) ? total_ff[FRAC_W-1:0]
                                           : FRAC_W'(total_ff[TOT_W-1:FRAC_W]);
   assign mul_out = PROD_W'(u_ff) * PROD_W'(mul_b);

   // Sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      u_in         = u_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      thr_in       = thr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pick_in      = pick_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff[IDX_W-1:0];
      mem_wdata    = total_ff + TOT_W'(req_weight);
      mem_raddr    = mid_calc[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req_opcode)
                  OP_CLEAR: begin
                     cnt_in       = '0;
                     total_in     = '0;
                     rsp_valid_in = 1'b1;
                     pick_in      = '0;
                     status_in    = ST_OK;
                  end
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ff >= CNT_W'(MAX_KEYS)) begin
                        pick_in   = PICK_W'(last_idx);
                        status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        total_in  = mem_wdata;
                        cnt_in    = cnt_ff + CNT_W'(1);
                        pick_in   = PICK_W'(cnt_ff);
                        status_in = ST_OK;
                     end
                  end
                  OP_DRAW: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        pick_in      = '0;
                        status_in    = ST_EMPTY;
                     end else begin
                        u_in     = req_uniform_fraction;
                        state_in = S_MUL_LO;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     pick_in      = PICK_W'(last_idx);
                     status_in    = ST_OK;
                  end
               endcase
            end
         end
         S_MUL_LO: begin
            prod_in  = mul_out;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            acc_in   = prod_ff[PROD_W-1:FRAC_W];
            prod_in  = mul_out;
            state_in = S_ADD;
         end
         S_ADD: begin
            // threshold = floor(u * total / 2^32)
            thr_in   = prod_ff[TOT_W-1:0] + TOT_W'(acc_ff);
            lo_in    = '0;
            hi_in    = cnt_ff;
            state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc[IDX_W-1:0];
               state_in = S_SRCH_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SRCH_CMP: begin
            if (rd_data_ff > thr_ff) begin
               hi_in = CNT_W'(mid_ff);
            end else begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end
            state_in = S_SRCH_RD;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pick_in      = (lo_ff >= cnt_ff) ? PICK_W'(last_idx) : PICK_W'(lo_ff);
               status_in    = ST_OK;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      u_ff      <= u_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      thr_ff    <= thr_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      pick_ff   <= pick_in;
      status_ff <= status_in;
   end

   // Table write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cum_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Table read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= cum_mem[mem_raddr];
   end

endmodule
